// File: src/battery_power_supervisor_core_assert.svh
// Assertion macros used by the checker of this block.
`ifndef BATTERY_POWER_SUPERVISOR_CORE_ASSERT_SVH
`define BATTERY_POWER_SUPERVISOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define BPS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("battery power supervisor check failed");

// Next-cycle implication, disabled while reset is high.
`define BPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("battery power supervisor check failed");

`endif

// File: src/bps_pkg.sv
package bps_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned TicksW  = 24;
  localparam int unsigned CountW  = 15;
  localparam int unsigned DebW    = 6;
  localparam int unsigned SecsW   = 4;
  localparam int unsigned OpW     = 3;
  localparam int unsigned IndexW  = 2;

  localparam int unsigned WarnPeriodInt = 1000;
  localparam int unsigned WarnPhaseInt  = 100;
  localparam int unsigned ShutTicksInt  = 10000;
  localparam int unsigned NumWarn       = ShutTicksInt / WarnPeriodInt;

  localparam logic [DebW-1:0] DebMax = 6'd50;
  localparam logic [DebW-1:0] DebHit = 6'd49;

  localparam logic signed [CountW-1:0] ShutTicks     = 15'sd10000;
  localparam logic signed [CountW-1:0] ServoTicks    = 15'sd5000;
  localparam logic signed [CountW-1:0] DischargeWait = 15'sd800;
  localparam logic signed [CountW-1:0] GoodSamples   = 15'sd5;

  localparam logic [SampleW-1:0] IdleThresholdReset   = 12'd3000;
  localparam logic [SampleW-1:0] CutoffThresholdReset = 12'd1600;
  localparam logic [TicksW-1:0]  DefaultOffTicksReset = 24'd15000;

  typedef enum logic [OpW-1:0] {
    OP_TICK         = 3'd0,
    OP_SET_HALT     = 3'd1,
    OP_SCHEDULE_OFF = 3'd2,
    OP_CANCEL_OFF   = 3'd3
  } op_t;

  typedef enum logic [IndexW-1:0] {
    REG_IDLE_THRESHOLD   = 2'd0,
    REG_CUTOFF_THRESHOLD = 2'd1,
    REG_DEFAULT_OFF      = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [SampleW-1:0] idle_threshold;
    logic [SampleW-1:0] cutoff_threshold;
    logic [TicksW-1:0]  default_off_ticks;
  } cfg_t;

  typedef struct packed {
    logic [OpW-1:0]     op;
    logic [SampleW-1:0] battery_sample;
    logic               button_level;
    logic               servos_on;
    logic               halt_value;
    logic [TicksW-1:0]  off_ticks;
  } item_t;

  typedef struct packed {
    logic                     battery_off;
    logic signed [CountW-1:0] low_count;
    logic                     halt_pending;
    logic [DebW-1:0]          debounce_count;
    logic                     button_state;
    logic                     countdown_active;
    logic [TicksW-1:0]        countdown;
    logic                     power_level;
  } state_t;

  typedef struct packed {
    logic             battery_shut;
    logic             servo_disable;
    logic             mission_stop;
    logic [SecsW-1:0] seconds_left;
    logic             low_warning;
    logic             button_pressed;
    logic             power_enable;
  } result_t;

  typedef struct packed {
    logic             hit;
    logic [SecsW-1:0] secs;
  } warn_t;

  // Warnings fall at counts 100, 1100, ... 9100; the seconds left count down from 9.
  function automatic warn_t warn_lookup(input logic signed [CountW-1:0] lc);
    warn_t w;
    w.hit  = 1'b0;
    w.secs = '0;
    for (int k = 0; k < NumWarn; k++) begin
      if (lc == CountW'(WarnPhaseInt + k * WarnPeriodInt)) begin
        w.hit  = 1'b1;
        w.secs = SecsW'(NumWarn - 1 - k);
      end
    end
    return w;
  endfunction

endpackage

// File: src/bps_step.sv
module bps_step
  import bps_pkg::*;
(
  input  state_t  st,
  input  cfg_t    cfg,
  input  item_t   it,
  output state_t  st_next,
  output result_t res
);

  logic signed [CountW-1:0] lc_inc;
  warn_t                    w;
  logic                     in_band;

  assign lc_inc  = st.low_count + 15'sd1;
  assign w       = warn_lookup(lc_inc);
  assign in_band = (it.battery_sample < cfg.idle_threshold) &&
                   (it.battery_sample > cfg.cutoff_threshold);

  always_comb begin
    st_next = st;
    res     = '0;
    case (op_t'(it.op))
      OP_SET_HALT: begin
        st_next.halt_pending = it.halt_value;
      end
      OP_SCHEDULE_OFF: begin
        st_next.countdown        = (it.off_ticks != '0) ? it.off_ticks : cfg.default_off_ticks;
        st_next.countdown_active = 1'b1;
      end
      OP_CANCEL_OFF: begin
        st_next.countdown_active = 1'b0;
      end
      OP_TICK: begin
        if (st.battery_off) begin
          if (st.low_count < 0) begin
            st_next.low_count = (lc_inc == '0) ? GoodSamples : lc_inc;
          end else if (it.battery_sample >= cfg.idle_threshold) begin
            if (st.low_count == '0) begin
              st_next.power_level  = 1'b1;
              st_next.battery_off  = 1'b0;
              st_next.halt_pending = 1'b0;
            end else begin
              st_next.low_count = st.low_count - 15'sd1;
            end
          end
        end else if (in_band || st.halt_pending) begin
          st_next.low_count = lc_inc;
          if (w.hit) begin
            res.low_warning  = 1'b1;
            res.mission_stop = 1'b1;
            res.seconds_left = w.secs;
            if ((lc_inc >= ServoTicks) && it.servos_on) begin
              res.servo_disable = 1'b1;
            end
          end
          if ((lc_inc > ShutTicks) || st.halt_pending) begin
            if (it.servos_on) begin
              res.servo_disable = 1'b1;
            end
            st_next.power_level = 1'b0;
            st_next.battery_off = 1'b1;
            st_next.low_count   = -DischargeWait;
          end
        end else begin
          st_next.low_count = '0;
        end

        if (it.button_level) begin
          if (st.debounce_count == DebHit) begin
            st_next.button_state = 1'b1;
          end
          if (st.debounce_count < DebMax) begin
            st_next.debounce_count = st.debounce_count + 6'd1;
          end
        end else begin
          if (st.debounce_count == 6'd1) begin
            st_next.button_state = 1'b0;
          end
          if (st.debounce_count > 6'd0) begin
            st_next.debounce_count = st.debounce_count - 6'd1;
          end
        end

        if (st.countdown_active) begin
          if (st.countdown <= 24'd1) begin
            st_next.countdown        = '0;
            st_next.power_level      = 1'b0;
            st_next.countdown_active = 1'b0;
          end else begin
            st_next.countdown = st.countdown - 24'd1;
          end
        end
      end
      default: begin
      end
    endcase
    res.power_enable   = st_next.power_level;
    res.button_pressed = st_next.button_state;
    res.battery_shut   = st_next.battery_off;
  end

endmodule

// File: src/battery_power_supervisor_core.sv
// Battery power supervisor. Each input item carries an op code on s_tuser and its operands on
// s_tdata; every item yields exactly one result item on m_tdata. One item is taken per clock
// cycle while the output register is free or its result is being taken. An accepted item is
// registered, the supervisor state is updated combinationally from that register, and the
// result is written to an output register, when that is free or being taken, and held there
// until it is taken. The combinational state update sets this rate. Configuration writes on
// the cfg channel are always ready and should be issued while the block is idle.
module battery_power_supervisor_core
  import bps_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [39:0]         s_tdata,  // battery_sample, button_level, servos_on, halt_value,
                                        // off_ticks, zero fill
  input  logic [OpW-1:0]      s_tuser,  // op
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [15:0]         m_tdata,  // power_enable, button_pressed, low_warning,
                                        // seconds_left, mission_stop, servo_disable,
                                        // battery_shut, zero fill
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IndexW-1:0]   cfg_index,
  input  logic [TicksW-1:0]   cfg_data
);

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_res;
  state_t  st;
  state_t  st_next;
  cfg_t    cfg;
  result_t res;
  logic    advance;

  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {6'd0, out_res};

  bps_step u_step (
    .st      (st),
    .cfg     (cfg),
    .it      (in_item),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.op             <= s_tuser;
      in_item.battery_sample <= s_tdata[11:0];
      in_item.button_level   <= s_tdata[12];
      in_item.servos_on      <= s_tdata[13];
      in_item.halt_value     <= s_tdata[14];
      in_item.off_ticks      <= s_tdata[38:15];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.battery_off      <= 1'b0;
      st.low_count        <= '0;
      st.halt_pending     <= 1'b0;
      st.debounce_count   <= '0;
      st.button_state     <= 1'b0;
      st.countdown_active <= 1'b0;
      st.countdown        <= '0;
      st.power_level      <= 1'b1;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.idle_threshold    <= IdleThresholdReset;
      cfg.cutoff_threshold  <= CutoffThresholdReset;
      cfg.default_off_ticks <= DefaultOffTicksReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_IDLE_THRESHOLD:   cfg.idle_threshold    <= cfg_data[SampleW-1:0];
        REG_CUTOFF_THRESHOLD: cfg.cutoff_threshold  <= cfg_data[SampleW-1:0];
        REG_DEFAULT_OFF:      cfg.default_off_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// File: src/bps_checker.sv
`include "battery_power_supervisor_core_assert.svh"

module bps_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // A result that waits must keep its contents.
  `BPS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // While battery-off holds, the power-hold output is low.
  `BPS_ASSERT_NOW(a_shut_no_power, clk, rst, m_tvalid && m_tdata[9], !m_tdata[0])

  // A warning always comes with a mission stop, and only with a warning.
  `BPS_ASSERT_NOW(a_warn_stop, clk, rst, m_tvalid, m_tdata[2] == m_tdata[7])

  // Seconds are reported only with a warning and never exceed nine.
  `BPS_ASSERT_NOW(a_secs, clk, rst, m_tvalid && (m_tdata[6:3] != 4'd0),
                  m_tdata[2] && (m_tdata[6:3] <= 4'd9))

endmodule

bind battery_power_supervisor_core bps_checker u_bps_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
